// ===== hw/rtl/avg_pkg.sv =====
// Shared constants, widths and the arctangent table for the arc vertex generator.
`timescale 1ns / 1ps
package avg_pkg;

  localparam int MAX_POINTS_DEF   = 64;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam int ANG_W = 36;
  localparam int CS_W  = 34;
  localparam int DVD_W = 64;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 36'sd1686629713;
  localparam logic signed [CS_W-1:0]  CORDIC_GAIN = 34'sh026DD3B6A;

  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0:  v = 32'h3243F6A8;
        5'd1:  v = 32'h1DAC6705;
        5'd2:  v = 32'h0FADBAFC;
        5'd3:  v = 32'h07F56EA6;
        5'd4:  v = 32'h03FEAB76;
        5'd5:  v = 32'h01FFD55B;
        5'd6:  v = 32'h00FFFAAA;
        5'd7:  v = 32'h007FFF55;
        5'd8:  v = 32'h003FFFEA;
        5'd9:  v = 32'h001FFFFD;
        5'd10: v = 32'h000FFFFF;
        5'd11: v = 32'h0007FFFF;
        5'd12: v = 32'h0003FFFF;
        5'd13: v = 32'h0001FFFF;
        5'd14: v = 32'h0000FFFF;
        5'd15: v = 32'h00007FFF;
        5'd16: v = 32'h00003FFF;
        5'd17: v = 32'h00001FFF;
        5'd18: v = 32'h00000FFF;
        5'd19: v = 32'h000007FF;
        5'd20: v = 32'h000003FF;
        5'd21: v = 32'h000001FF;
        5'd22: v = 32'h000000FF;
        5'd23: v = 32'h0000007F;
        5'd24: v = 32'h0000003F;
        5'd25: v = 32'h0000001F;
        5'd26: v = 32'h0000000F;
        5'd27: v = 32'h00000008;
        5'd28: v = 32'h00000004;
        5'd29: v = 32'h00000002;
        5'd30: v = 32'h00000001;
        default: v = 32'h00000000;
      endcase
      return {4'b0, v};
    end
  endfunction

endpackage

// ===== hw/rtl/avg_cordic.sv =====
// Iterative rotation-mode CORDIC: range reduction then one micro-rotation per cycle.
`timescale 1ns / 1ps
module avg_cordic import avg_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [31:0]     angle,
  output logic signed [CS_W-1:0] cos_out,
  output logic signed [CS_W-1:0] sin_out,
  output logic                   done
);

  localparam int IW = $clog2(CORDIC_STEPS + 1);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RED  = 2'd1;
  localparam logic [1:0] C_ROT  = 2'd2;

  logic [1:0]              state;
  logic [IW-1:0]           iter;
  logic signed [ANG_W-1:0] a;
  logic signed [CS_W-1:0]  x, y;
  logic                    neg;

  logic signed [CS_W-1:0]  dx, dy;
  logic signed [ANG_W-1:0] at;

  assign dx = y >>> iter;
  assign dy = x >>> iter;
  assign at = atan_q30(5'(iter));

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= C_IDLE;
      iter  <= '0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (start) begin
            a     <= {{2{angle[31]}}, angle, 2'b00};
            x     <= CORDIC_GAIN;
            y     <= '0;
            neg   <= 1'b0;
            iter  <= '0;
            state <= C_RED;
          end
        end
        C_RED: begin
          if (a > ANG_PI) begin
            a <= a - ANG_TWO_PI;
          end else if (a < -ANG_PI) begin
            a <= a + ANG_TWO_PI;
          end else begin
            if (a > ANG_HALF_PI) begin
              a   <= a - ANG_PI;
              neg <= 1'b1;
            end else if (a < -ANG_HALF_PI) begin
              a   <= a + ANG_PI;
              neg <= 1'b1;
            end
            state <= C_ROT;
          end
        end
        C_ROT: begin
          if (iter == IW'(CORDIC_STEPS)) begin
            cos_out <= neg ? -x : x;
            sin_out <= neg ? -y : y;
            done    <= 1'b1;
            state   <= C_IDLE;
          end else begin
            if (a >= 0) begin
              x <= x - dx;
              y <= y + dy;
              a <= a - at;
            end else begin
              x <= x + dx;
              y <= y - dy;
              a <= a + at;
            end
            iter <= iter + 1'b1;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/avg_divider.sv =====
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module avg_divider import avg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic signed [CS_W-1:0]  divisor,
  output logic signed [DVD_W-1:0] quotient,
  output logic                    done
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             running;
  logic [CW-1:0]    cnt;
  logic [DVD_W-1:0] q;
  logic [CS_W-1:0]  rem;
  logic [CS_W-1:0]  dmag;
  logic             qneg;

  logic [CS_W:0]    rs;
  logic             ge;

  assign rs = {rem, q[DVD_W-1]};
  assign ge = rs >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (!running) begin
      if (start) begin
        q       <= dividend[DVD_W-1] ? DVD_W'(-dividend) : dividend;
        dmag    <= divisor[CS_W-1] ? CS_W'(-divisor) : divisor;
        qneg    <= dividend[DVD_W-1] ^ divisor[CS_W-1];
        rem     <= '0;
        cnt     <= '0;
        running <= 1'b1;
      end
    end else if (cnt == CW'(DVD_W)) begin
      quotient <= qneg ? -$signed(q) : $signed(q);
      done     <= 1'b1;
      running  <= 1'b0;
    end else begin
      rem <= ge ? CS_W'(rs - {1'b0, dmag}) : rs[CS_W-1:0];
      q   <= {q[DVD_W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// ===== hw/rtl/arc_vertex_generator_unit.sv =====
// Top level: arc set-up sequencer, shared multiplier and vertex output register.
// First vertex registered after two CORDIC runs, two divisions and two radius products; a
// whole-turn wrap lengthens a run; zero step cosine: no second division; count 1: one run only.
// Each further vertex is formed from four split products on one 33x32 multiplier.
// A request with count 0 is accepted and emits nothing; busy until the last vertex.
// Synchronous active-high reset returns the sequencer to idle with no strobe.
`timescale 1ns / 1ps
module arc_vertex_generator_unit import avg_pkg::*; #(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic [30:0]        radius,
  input  logic signed [31:0] first_angle,
  input  logic signed [31:0] sweep_angle,
  input  logic [6:0]         point_count,
  output logic               strobe,
  output logic signed [31:0] vertex_x,
  output logic signed [31:0] vertex_y,
  output logic               last_point,
  output logic               saturated
);

  localparam int PLW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_C0    = 4'd1;
  localparam logic [3:0] S_C0W   = 4'd2;
  localparam logic [3:0] S_MLO   = 4'd3;
  localparam logic [3:0] S_MHI   = 4'd4;
  localparam logic [3:0] S_MFIN  = 4'd5;
  localparam logic [3:0] S_DIV0  = 4'd6;
  localparam logic [3:0] S_DIV0W = 4'd7;
  localparam logic [3:0] S_C1    = 4'd8;
  localparam logic [3:0] S_C1W   = 4'd9;
  localparam logic [3:0] S_DIV1  = 4'd10;
  localparam logic [3:0] S_DIV1W = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  localparam logic [2:0] J_RX = 3'd0;
  localparam logic [2:0] J_RY = 3'd1;
  localparam logic [2:0] J_NX = 3'd2;
  localparam logic [2:0] J_NY = 3'd3;
  localparam logic [2:0] J_CX = 3'd4;
  localparam logic [2:0] J_CY = 3'd5;

  localparam logic signed [47:0] RUN_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] RUN_MIN = {1'b1, {47{1'b0}}};

  logic [3:0]              state;
  logic [2:0]              job;
  logic [PLW-1:0]          points_left;
  logic signed [31:0]      held_center_x, held_center_y;
  logic [30:0]             r;
  logic signed [31:0]      start_ang, sweep;
  logic signed [31:0]      theta;
  logic signed [CS_W-1:0]  c0, s0, c1, s1;
  logic signed [47:0]      run_x, run_y, nx, ny;
  logic signed [31:0]      tan_step, cos_step;
  logic signed [64:0]      prod, plo;

  logic                    cs_start;
  logic signed [31:0]      cs_angle;
  logic signed [CS_W-1:0]  cs_cos, cs_sin;
  logic                    cs_done;

  logic                    dv_start;
  logic signed [DVD_W-1:0] dv_dividend;
  logic signed [CS_W-1:0]  dv_divisor;
  logic signed [DVD_W-1:0] dv_quo;
  logic                    dv_done;

  logic signed [47:0]      opa;
  logic signed [31:0]      opb;
  logic signed [32:0]      mul_a;
  logic signed [81:0]      full, shifted, acc;
  logic signed [47:0]      acc_c;
  logic [PLW-1:0]          n_eff;

  function automatic logic signed [47:0] clamp48(input logic signed [81:0] v);
    if (v > 82'(RUN_MAX)) return RUN_MAX;
    if (v < 82'(RUN_MIN)) return RUN_MIN;
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [33:0] place(input logic signed [47:0] run,
                                                input logic signed [31:0] ctr);
    logic signed [48:0] rr;
    begin
      rr = 49'(run) + 49'sd32768;
      return 34'(rr >>> 16) + 34'(ctr);
    end
  endfunction

  avg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cs_start), .angle(cs_angle),
    .cos_out(cs_cos), .sin_out(cs_sin), .done(cs_done)
  );

  avg_divider u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_dividend),
    .divisor(dv_divisor), .quotient(dv_quo), .done(dv_done)
  );

  assign busy     = state != S_IDLE;
  assign cs_start = (state == S_C0) || (state == S_C1);
  assign cs_angle = (state == S_C0) ? start_ang : theta;
  assign dv_start = (state == S_DIV0) || (state == S_DIV1);
  assign dv_dividend = (state == S_DIV0) ? DVD_W'(sweep) : (DVD_W'(s1) <<< 28);
  assign dv_divisor  = (state == S_DIV0) ? CS_W'(points_left - 1'b1) : c1;

  assign n_eff = (int'(point_count) > MAX_POINTS) ? PLW'(MAX_POINTS) : PLW'(point_count);

  always_comb begin
    case (job)
      J_RX:    begin opa = 48'({17'b0, r}); opb = 32'(c0); end
      J_RY:    begin opa = 48'({17'b0, r}); opb = 32'(s0); end
      J_NX:    begin opa = run_y;           opb = tan_step; end
      J_NY:    begin opa = run_x;           opb = tan_step; end
      J_CX:    begin opa = nx;              opb = cos_step; end
      default: begin opa = ny;              opb = cos_step; end
    endcase
    mul_a = (state == S_MLO) ? $signed({17'b0, opa[15:0]}) : 33'($signed(opa[47:16]));
    full  = (82'(prod) <<< 16) + 82'(plo);
    case (job) inside
      J_RX, J_RY: shifted = full >>> 14;
      J_NX, J_NY: shifted = full >>> 28;
      default:    shifted = full >>> 30;
    endcase
    case (job)
      J_NX:    acc = 82'(run_x) - shifted;
      J_NY:    acc = 82'(run_y) + shifted;
      default: acc = shifted;
    endcase
    acc_c = clamp48(acc);
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * opb;
  end

  always_ff @(posedge clk) begin
    logic signed [33:0] vx, vy;
    vx = place(run_x, held_center_x);
    vy = place(run_y, held_center_y);
    strobe <= 1'b0;
    if (rst) begin
      state       <= S_IDLE;
      job         <= J_RX;
      points_left <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            held_center_x <= center_x;
            held_center_y <= center_y;
            r             <= radius;
            start_ang     <= first_angle;
            sweep         <= sweep_angle;
            points_left   <= n_eff;
            if (n_eff != '0) state <= S_C0;
          end
        end
        S_C0: state <= S_C0W;
        S_C0W: begin
          if (cs_done) begin
            c0    <= cs_cos;
            s0    <= cs_sin;
            job   <= J_RX;
            state <= S_MLO;
          end
        end
        S_MLO: state <= S_MHI;
        S_MHI: begin
          plo   <= prod;
          state <= S_MFIN;
        end
        S_MFIN: begin
          state <= S_MLO;
          case (job)
            J_RX: begin run_x <= acc_c; job <= J_RY; end
            J_RY: begin
              run_y <= acc_c;
              if (points_left == PLW'(1)) begin
                tan_step <= '0;
                cos_step <= 32'sh40000000;
                state    <= S_EMIT;
              end else begin
                state <= S_DIV0;
              end
            end
            J_NX: begin nx <= acc_c; job <= J_NY; end
            J_NY: begin ny <= acc_c; job <= J_CX; end
            J_CX: begin run_x <= acc_c; job <= J_CY; end
            default: begin run_y <= acc_c; state <= S_EMIT; end
          endcase
        end
        S_DIV0: state <= S_DIV0W;
        S_DIV0W: begin
          if (dv_done) begin
            theta <= dv_quo[31:0];
            state <= S_C1;
          end
        end
        S_C1: state <= S_C1W;
        S_C1W: begin
          if (cs_done) begin
            c1       <= cs_cos;
            s1       <= cs_sin;
            cos_step <= clamp32(64'(cs_cos));
            if (cs_cos == '0) begin
              tan_step <= (cs_sin > 0) ? 32'sh7FFFFFFF :
                          ((cs_sin < 0) ? 32'sh80000000 : 32'sh0);
              state    <= S_EMIT;
            end else begin
              state <= S_DIV1;
            end
          end
        end
        S_DIV1: state <= S_DIV1W;
        S_DIV1W: begin
          if (dv_done) begin
            tan_step <= clamp32(dv_quo);
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          strobe     <= 1'b1;
          vertex_x   <= clamp32(64'(vx));
          vertex_y   <= clamp32(64'(vy));
          saturated  <= (vx != 34'(clamp32(64'(vx)))) || (vy != 34'(clamp32(64'(vy))));
          last_point <= points_left == PLW'(1);
          points_left <= points_left - 1'b1;
          if (points_left == PLW'(1)) begin
            state <= S_IDLE;
          end else begin
            job   <= J_NX;
            state <= S_MLO;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
